// ===== design/atn_pkg.sv =====
package atn_pkg;

    // Width of a time of day held as seconds (fits fields as given, plus lead)
    localparam int SEC_W = 17;

    localparam logic [SEC_W-1:0] DAY_SECONDS = 17'd86400;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } hms_t;

    localparam int HMS_W = $bits(hms_t);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_TIME = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_NO_SLOT  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_FLUSH1,
        ST_FLUSH2,
        ST_FINISH
    } state_t;

    // Seconds since midnight; constant multiplies reduce to shift-add
    function automatic logic [SEC_W-1:0] to_seconds(input hms_t t);
        logic [SEC_W-1:0] h_part;
        logic [SEC_W-1:0] m_part;
        h_part = SEC_W'(t.hours) * SEC_W'(3600);
        m_part = SEC_W'(t.minutes) * SEC_W'(60);
        return h_part + m_part + SEC_W'(t.seconds);
    endfunction

endpackage

// ===== design/atn_slot_ram.sv =====
module atn_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  atn_pkg::hms_t            wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output atn_pkg::hms_t            rd_data
);

    atn_pkg::hms_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/alarm_table_next_alarm_top.sv =====
// Channel   Direction  Handshake                Payload
// in        in         in_valid / in_ready      cmd, alarm_*, remove_slot, now_*
// out       out        out_valid / out_ready    status, slot_used, alarm_count, next_*
// cfg       in         cfg_wr_en (no wait)      cfg_wr_data -> lead_seconds
//
// A beat runs from its acceptance in ST_IDLE through ST_PREP, one pass of the slot RAM read
// port over every slot in ST_SCAN, ST_FLUSH1 and ST_FLUSH2 to drain the compare pipeline and
// ST_FINISH to load the result; the next beat is accepted once the state is back in ST_IDLE.
// Reset clears the slot table marks, the count and all handshakes; lead_seconds returns to 1.
// A stalled output beat is held in the output register while the next input beat is
// already accepted and worked on; that beat waits in its load cycle until the first is taken.
module alarm_table_next_alarm_top #(
    parameter int SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [4:0] alarm_hours,
    input  logic [5:0] alarm_minutes,
    input  logic [5:0] alarm_seconds,
    input  logic [5:0] remove_slot,
    input  logic [4:0] now_hours,
    input  logic [5:0] now_minutes,
    input  logic [5:0] now_seconds,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [5:0] slot_used,
    output logic [6:0] alarm_count,
    output logic       next_valid,
    output logic [4:0] next_hours,
    output logic [5:0] next_minutes,
    output logic [5:0] next_seconds,

    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SW    = atn_pkg::SEC_W;

    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(SLOTS - 1);
    localparam logic [6:0]       SLOTS_CNT = 7'(SLOTS);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    atn_pkg::state_t state_reg, state_next;
    logic            issue;
    logic            load_out;
    logic            out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = atn_pkg::ST_PREP;
                end
            end
            atn_pkg::ST_PREP:   state_next = atn_pkg::ST_SCAN;
            atn_pkg::ST_SCAN:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = atn_pkg::ST_FLUSH1;
                end
            end
            atn_pkg::ST_FLUSH1: state_next = atn_pkg::ST_FLUSH2;
            atn_pkg::ST_FLUSH2: state_next = atn_pkg::ST_FINISH;
            atn_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = atn_pkg::ST_IDLE;
                end
            end
            default:            state_next = atn_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            atn_pkg::ST_IDLE:   in_ready = 1'b1;
            atn_pkg::ST_SCAN:   issue    = 1'b1;
            atn_pkg::ST_FINISH: load_out = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Captured beat
    // ---------------------------------------------------------------
    logic            cmd_reg;
    atn_pkg::hms_t   alarm_reg;
    atn_pkg::hms_t   now_reg;
    logic [5:0]      idx_reg;
    logic [5:0]      lead_reg;

    // ---------------------------------------------------------------
    // Slot table state
    // ---------------------------------------------------------------
    logic [SLOTS-1:0] active_reg, active_next;
    logic [6:0]       count_reg, count_next;
    logic             add_pend_reg, add_pend_next;
    atn_pkg::status_t status_reg, status_next;
    logic [5:0]       used_reg, used_next;
    logic [SW-1:0]    target_reg, target_next;

    logic [IDX_W-1:0] cur;
    logic             wr_slot;
    atn_pkg::hms_t    rd_hms;

    assign cur     = cnt_reg[IDX_W-1:0];
    assign wr_slot = issue && add_pend_reg && !active_reg[cur];

    atn_slot_ram #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_slot),
        .wr_addr (cur),
        .wr_data (alarm_reg),
        .rd_addr (cur),
        .rd_data (rd_hms)
    );

    // ---------------------------------------------------------------
    // Compare pipeline: convert, then distance and keep the nearest
    // ---------------------------------------------------------------
    logic             p1_valid_reg, p1_valid_next;
    logic             p1_bypass_reg, p1_bypass_next;
    logic             p2_valid_reg;
    logic [SW-1:0]    p2_sec_reg;
    atn_pkg::hms_t    p2_hms_reg;
    logic             best_valid_reg, best_valid_next;
    logic [SW-1:0]    best_diff_reg, best_diff_next;
    atn_pkg::hms_t    best_hms_reg, best_hms_next;

    atn_pkg::hms_t    p1_hms;
    logic [SW-1:0]    ahead_sec;
    logic [SW-1:0]    now_sum;
    logic             bad_time;
    logic             idx_ok;

    // A slot written during this pass is not in the RAM output yet: bypass it
    assign p1_hms = p1_bypass_reg ? alarm_reg : rd_hms;

    // Circular distance from target, both operands below one day
    assign ahead_sec = (p2_sec_reg >= target_reg) ? (p2_sec_reg - target_reg)
                     : (atn_pkg::DAY_SECONDS - (target_reg - p2_sec_reg));

    assign now_sum  = atn_pkg::to_seconds(now_reg) + SW'(lead_reg);
    assign bad_time = (alarm_reg.hours > 5'd23) || (alarm_reg.minutes > 6'd59)
                   || (alarm_reg.seconds > 6'd59);
    assign idx_ok   = ({1'b0, idx_reg} < SLOTS_CNT) && active_reg[idx_reg[IDX_W-1:0]];

    always_comb
    begin
        cnt_next        = cnt_reg;
        active_next     = active_reg;
        count_next      = count_reg;
        add_pend_next   = add_pend_reg;
        status_next     = status_reg;
        used_next       = used_reg;
        target_next     = target_reg;
        p1_valid_next   = 1'b0;
        p1_bypass_next  = 1'b0;
        best_valid_next = best_valid_reg;
        best_diff_next  = best_diff_reg;
        best_hms_next   = best_hms_reg;

        if (state_reg == atn_pkg::ST_PREP)
        begin
            // Fold the sum back into one day; it stays below two days
            target_next     = (now_sum >= atn_pkg::DAY_SECONDS)
                            ? (now_sum - atn_pkg::DAY_SECONDS) : now_sum;
            cnt_next        = '0;
            best_valid_next = 1'b0;
            add_pend_next   = 1'b0;
            if (cmd_reg == atn_pkg::CMD_ADD)
            begin
                used_next = '0;
                if (bad_time)
                begin
                    status_next = atn_pkg::STATUS_BAD_TIME;
                end
                else if (count_reg >= SLOTS_CNT)
                begin
                    status_next = atn_pkg::STATUS_FULL;
                end
                else
                begin
                    status_next   = atn_pkg::STATUS_OK;
                    add_pend_next = 1'b1;
                end
            end
            else
            begin
                used_next = idx_reg;
                if (idx_ok)
                begin
                    status_next                       = atn_pkg::STATUS_OK;
                    active_next[idx_reg[IDX_W-1:0]]   = 1'b0;
                    count_next                        = count_reg - 7'd1;
                end
                else
                begin
                    status_next = atn_pkg::STATUS_NO_SLOT;
                end
            end
        end

        if (issue)
        begin
            cnt_next       = cnt_reg + CNT_W'(1);
            p1_valid_next  = active_reg[cur] || wr_slot;
            p1_bypass_next = wr_slot;
            // Lowest free slot takes the new alarm on the way past
            if (wr_slot)
            begin
                active_next[cur] = 1'b1;
                count_next       = count_reg + 7'd1;
                add_pend_next    = 1'b0;
                used_next        = 6'(cur);
            end
        end

        // Strict compare keeps the lower slot on a tie
        if (p2_valid_reg && (!best_valid_reg || ahead_sec < best_diff_reg))
        begin
            best_valid_next = 1'b1;
            best_diff_next  = ahead_sec;
            best_hms_next   = p2_hms_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= atn_pkg::ST_IDLE;
            cnt_reg        <= '0;
            active_reg     <= '0;
            count_reg      <= '0;
            add_pend_reg   <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p1_bypass_reg  <= 1'b0;
            p2_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            lead_reg       <= 6'd1;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            active_reg     <= active_next;
            count_reg      <= count_next;
            add_pend_reg   <= add_pend_next;
            p1_valid_reg   <= p1_valid_next;
            p1_bypass_reg  <= p1_bypass_next;
            p2_valid_reg   <= p1_valid_reg;
            best_valid_reg <= best_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                lead_reg <= cfg_wr_data;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    logic [1:0] status_out_reg;
    logic [5:0] used_out_reg;
    logic [6:0] count_out_reg;
    logic       next_valid_reg;
    atn_pkg::hms_t next_hms_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd;
            alarm_reg <= '{hours: alarm_hours, minutes: alarm_minutes,
                           seconds: alarm_seconds};
            now_reg   <= '{hours: now_hours, minutes: now_minutes,
                           seconds: now_seconds};
            idx_reg   <= remove_slot;
        end
        status_reg    <= status_next;
        used_reg      <= used_next;
        target_reg    <= target_next;
        p2_sec_reg    <= atn_pkg::to_seconds(p1_hms);
        p2_hms_reg    <= p1_hms;
        best_diff_reg <= best_diff_next;
        best_hms_reg  <= best_hms_next;
        // Hold the result beat until taken
        if (load_out)
        begin
            status_out_reg <= status_reg;
            used_out_reg   <= used_reg;
            count_out_reg  <= count_reg;
            next_valid_reg <= best_valid_reg;
            next_hms_reg   <= best_valid_reg ? best_hms_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_out_reg;
    assign slot_used    = used_out_reg;
    assign alarm_count  = count_out_reg;
    assign next_valid   = next_valid_reg;
    assign next_hours   = next_hms_reg.hours;
    assign next_minutes = next_hms_reg.minutes;
    assign next_seconds = next_hms_reg.seconds;

endmodule

// ===== bench/alarm_table_next_alarm_checker.sv =====
`timescale 1ns / 100ps

module alarm_table_next_alarm_checker #(
    parameter int SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       cmd,
    input  logic [4:0] alarm_hours,
    input  logic [5:0] alarm_minutes,
    input  logic [5:0] alarm_seconds,
    input  logic [5:0] remove_slot,
    input  logic [4:0] now_hours,
    input  logic [5:0] now_minutes,
    input  logic [5:0] now_seconds,

    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [1:0] status,
    input  logic [5:0] slot_used,
    input  logic [6:0] alarm_count,
    input  logic       next_valid,
    input  logic [4:0] next_hours,
    input  logic [5:0] next_minutes,
    input  logic [5:0] next_seconds,

    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,

    output int         fail_count,
    output int         pending_beats
);

    typedef struct packed {
        atn_pkg::status_t status;
        logic [5:0]       slot;
        logic [6:0]       count;
        logic             found;
        logic [4:0]       hours;
        logic [5:0]       minutes;
        logic [5:0]       seconds;
    } alarm_result_t;

    localparam int DAY   = int'(atn_pkg::DAY_SECONDS);
    localparam int TOD_W = atn_pkg::SEC_W;

    // Shadow copy of the alarm table and the lead register
    logic             slot_on  [SLOTS];
    logic [TOD_W-1:0] slot_tod [SLOTS];
    logic [6:0]       n_active;
    logic [5:0]       lead;

    alarm_result_t    due_alarms[$];

    // Apply one beat to the shadow table and work out the result it causes
    function automatic alarm_result_t predict_next_alarm(
        input logic       op,
        input logic [4:0] ah,
        input logic [5:0] am,
        input logic [5:0] as_,
        input logic [5:0] rs,
        input logic [4:0] nh,
        input logic [5:0] nm,
        input logic [5:0] ns
    );
        alarm_result_t r;
        int            free_i;
        int            tgt;
        int            d;
        int            t;
        int            best_d;
        int            best_t;
        bit            found;
        r        = '0;
        r.status = atn_pkg::STATUS_OK;
        found    = 1'b0;
        best_d   = 0;
        best_t   = 0;
        if (op == atn_pkg::CMD_ADD)
        begin
            if (ah > 23 || am > 59 || as_ > 59)
            begin
                r.status = atn_pkg::STATUS_BAD_TIME;
            end
            else if (n_active >= SLOTS)
            begin
                r.status = atn_pkg::STATUS_FULL;
            end
            else
            begin
                free_i = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!slot_on[i] && free_i < 0)
                        free_i = i;
                end
                if (free_i < 0)
                begin
                    r.status = atn_pkg::STATUS_FULL;
                end
                else
                begin
                    slot_on[free_i]  = 1'b1;
                    slot_tod[free_i] = TOD_W'(int'(ah) * 3600 + int'(am) * 60 + int'(as_));
                    n_active         = n_active + 7'd1;
                    r.slot           = 6'(free_i);
                end
            end
        end
        else
        begin
            r.slot = rs;
            if (int'(rs) >= SLOTS || !slot_on[rs])
            begin
                r.status = atn_pkg::STATUS_NO_SLOT;
            end
            else
            begin
                slot_on[rs] = 1'b0;
                if (n_active > 0)
                    n_active = n_active - 7'd1;
            end
        end

        // Nearest alarm at or after now + lead, wrapping at midnight
        tgt = (int'(nh) * 3600 + int'(nm) * 60 + int'(ns) + int'(lead)) % DAY;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_on[i])
            begin
                t = int'(slot_tod[i]) % DAY;
                d = (t + DAY - tgt) % DAY;
                if (!found || d < best_d)
                begin
                    found  = 1'b1;
                    best_d = d;
                    best_t = t;
                end
            end
        end
        r.count = n_active;
        if (found)
        begin
            r.found   = 1'b1;
            r.hours   = 5'(best_t / 3600);
            r.minutes = 6'((best_t / 60) % 60);
            r.seconds = 6'(best_t % 60);
        end
        return r;
    endfunction

    task automatic report_fault(input string what);
        if (fail_count < 10)
            $display("%0t ns: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        alarm_result_t seen;
        alarm_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_on[i]  = 1'b0;
                slot_tod[i] = '0;
            end
            n_active = '0;
            lead     = 6'd1;
            due_alarms.delete();
            pending_beats = 0;
        end
        else
        begin
            // Retire the output beat first: it always belongs to an earlier input beat
            if (out_valid && out_ready)
            begin
                seen = {status, slot_used, alarm_count, next_valid,
                        next_hours, next_minutes, next_seconds};
                if (due_alarms.size() == 0)
                begin
                    report_fault("output beat with no result outstanding");
                end
                else
                begin
                    want = due_alarms.pop_front();
                    if (seen !== want)
                        report_fault($sformatf(
                            {"mismatch exp st=%0d slot=%0d cnt=%0d nv=%0d %0d:%0d:%0d",
                             " got st=%0d slot=%0d cnt=%0d nv=%0d %0d:%0d:%0d"},
                            want.status, want.slot, want.count, want.found,
                            want.hours, want.minutes, want.seconds,
                            seen.status, seen.slot, seen.count, seen.found,
                            seen.hours, seen.minutes, seen.seconds));
                end
            end
            if (in_valid && in_ready)
                due_alarms.push_back(predict_next_alarm(cmd, alarm_hours, alarm_minutes,
                                                        alarm_seconds, remove_slot,
                                                        now_hours, now_minutes,
                                                        now_seconds));
            if (cfg_wr_en)
                lead = cfg_wr_data;
            pending_beats = due_alarms.size();
        end
    end

endmodule

// ===== bench/tb_alarm_table_next_alarm_top.sv =====
`timescale 1ns / 100ps

module tb_alarm_table_next_alarm_top;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 50;

    localparam logic OP_ADD    = atn_pkg::CMD_ADD;
    localparam logic OP_REMOVE = atn_pkg::CMD_REMOVE;

    logic       clk;
    logic       rst_n;

    logic       in_valid;
    logic       in_ready;
    logic       cmd;
    logic [4:0] alarm_hours;
    logic [5:0] alarm_minutes;
    logic [5:0] alarm_seconds;
    logic [5:0] remove_slot;
    logic [4:0] now_hours;
    logic [5:0] now_minutes;
    logic [5:0] now_seconds;

    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [5:0] slot_used;
    logic [6:0] alarm_count;
    logic       next_valid;
    logic [4:0] next_hours;
    logic [5:0] next_minutes;
    logic [5:0] next_seconds;

    logic       cfg_wr_en;
    logic [5:0] cfg_wr_data;

    int         fail_count;
    int         pending_beats;
    int         cycle_count;

    // Set while a stretch of the run is to go without idling on one side
    bit         tx_steady;
    bit         rx_steady;

    // Registered record of an input handshake, read back at the falling edge
    logic       in_beat;

    alarm_table_next_alarm_top #(
        .SLOTS(SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .alarm_hours  (alarm_hours),
        .alarm_minutes(alarm_minutes),
        .alarm_seconds(alarm_seconds),
        .remove_slot  (remove_slot),
        .now_hours    (now_hours),
        .now_minutes  (now_minutes),
        .now_seconds  (now_seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot_used    (slot_used),
        .alarm_count  (alarm_count),
        .next_valid   (next_valid),
        .next_hours   (next_hours),
        .next_minutes (next_minutes),
        .next_seconds (next_seconds),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    alarm_table_next_alarm_checker #(
        .SLOTS(SLOTS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .alarm_hours  (alarm_hours),
        .alarm_minutes(alarm_minutes),
        .alarm_seconds(alarm_seconds),
        .remove_slot  (remove_slot),
        .now_hours    (now_hours),
        .now_minutes  (now_minutes),
        .now_seconds  (now_seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot_used    (slot_used),
        .alarm_count  (alarm_count),
        .next_valid   (next_valid),
        .next_hours   (next_hours),
        .next_minutes (next_minutes),
        .next_seconds (next_seconds),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending_beats(pending_beats)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_beat <= 1'b0;
        else
            in_beat <= in_valid && in_ready;
    end

    // Idle length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Receiver: stall out_ready at random, except during steady stretches
    initial
    begin : receiver
        int rx_hold;
        out_ready = 1'b0;
        rx_hold   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                if (rx_hold == 0)
                    out_ready <= 1'b1;
            end
            else if (!rx_steady && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                rx_hold = gap_len();
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it overstays the cycle budget
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one beat; called at a falling edge, returns at the falling edge after acceptance.
    // Valid is only dropped when a gap precedes this beat; otherwise it stays high between beats.
    task automatic send_alarm_beat(
        input logic       op,
        input logic [4:0] ah,
        input logic [5:0] am,
        input logic [5:0] as_,
        input logic [5:0] rs,
        input logic [4:0] nh,
        input logic [5:0] nm,
        input logic [5:0] ns
    );
        int gap;
        gap = 0;
        if (!tx_steady && $urandom_range(0, 99) >= 40)
            gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        alarm_hours   <= ah;
        alarm_minutes <= am;
        alarm_seconds <= as_;
        remove_slot   <= rs;
        now_hours     <= nh;
        now_minutes   <= nm;
        now_seconds   <= ns;
        @(negedge clk);
        while (!in_beat)
            @(negedge clk);
    endtask

    // Build a mostly well-formed beat; add_pct steers the table towards full or empty
    task automatic send_random_beat(input int add_pct);
        logic       op;
        logic [4:0] ah;
        logic [5:0] am;
        logic [5:0] as_;
        logic [5:0] rs;
        logic [4:0] nh;
        logic [5:0] nm;
        logic [5:0] ns;
        int         r;
        op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE;
        r  = $urandom_range(0, 99);
        if (r < 15)
        begin
            // Raw field values, bad times among them
            ah  = 5'($urandom);
            am  = 6'($urandom);
            as_ = 6'($urandom);
        end
        else if (r < 35)
        begin
            // Times near midnight from a small set, so ties and wraps come up
            ah  = $urandom_range(0, 1) ? 5'd23 : 5'd0;
            am  = $urandom_range(0, 1) ? 6'd59 : 6'd0;
            as_ = $urandom_range(0, 1) ? 6'd59 : 6'd0;
        end
        else
        begin
            ah  = 5'($urandom_range(0, 23));
            am  = 6'($urandom_range(0, 59));
            as_ = 6'($urandom_range(0, 59));
        end
        if ($urandom_range(0, 99) < 85)
            rs = 6'($urandom_range(0, SLOTS - 1));
        else
            rs = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 19) == 0)
        begin
            nh = 5'($urandom);
            nm = 6'($urandom);
            ns = 6'($urandom);
        end
        else
        begin
            nh = 5'($urandom_range(0, 23));
            nm = 6'($urandom_range(0, 59));
            ns = 6'($urandom_range(0, 59));
        end
        send_alarm_beat(op, ah, am, as_, rs, nh, nm, ns);
    endtask

    // Hold the sender until every outstanding result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_beats != 0)
            @(negedge clk);
    endtask

    // Write lead_seconds with the block idle
    task automatic write_lead(input logic [5:0] value);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int add_pct;
        // Drive every input to a known value from time zero
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd           = OP_ADD;
        alarm_hours   = '0;
        alarm_minutes = '0;
        alarm_seconds = '0;
        remove_slot   = '0;
        now_hours     = '0;
        now_minutes   = '0;
        now_seconds   = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, lead at its reset value of one second
        // Remove from an empty table: flagged, no next alarm
        send_alarm_beat(OP_REMOVE, 5'd0, 6'd0, 6'd0, 6'd0, 5'd12, 6'd0, 6'd0);
        // Last second of the day, seen from midnight
        send_alarm_beat(OP_ADD, 5'd23, 6'd59, 6'd59, 6'd0, 5'd0, 6'd0, 6'd0);
        // Now plus lead wraps to midnight: alarm at exactly the target, distance zero
        send_alarm_beat(OP_ADD, 5'd0, 6'd0, 6'd0, 6'd0, 5'd23, 6'd59, 6'd59);
        // Same time again: the lower slot must win the tie
        send_alarm_beat(OP_ADD, 5'd0, 6'd0, 6'd0, 6'd0, 5'd23, 6'd59, 6'd59);
        // Bad hour, then every alarm field at its top value
        send_alarm_beat(OP_ADD, 5'd24, 6'd0, 6'd0, 6'd0, 5'd6, 6'd30, 6'd0);
        send_alarm_beat(OP_ADD, 5'd31, 6'd63, 6'd63, 6'd63, 5'd23, 6'd59, 6'd59);
        // Slots beyond the table
        send_alarm_beat(OP_REMOVE, 5'd0, 6'd0, 6'd0, 6'd63, 5'd1, 6'd2, 6'd3);
        send_alarm_beat(OP_REMOVE, 5'd0, 6'd0, 6'd0, 6'd16, 5'd1, 6'd2, 6'd3);
        // Clear a live slot, then the same slot again once it is empty
        send_alarm_beat(OP_REMOVE, 5'd0, 6'd0, 6'd0, 6'd1, 5'd23, 6'd59, 6'd59);
        send_alarm_beat(OP_REMOVE, 5'd0, 6'd0, 6'd0, 6'd1, 5'd23, 6'd59, 6'd59);
        // Current clock out of range; the add refills the freed slot
        send_alarm_beat(OP_ADD, 5'd12, 6'd30, 6'd30, 6'd0, 5'd31, 6'd63, 6'd63);
        // Fill the table, then one add too many
        repeat (SLOTS - 3)
            send_alarm_beat(OP_ADD, 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                            6'($urandom_range(0, 59)), 6'd0, 5'($urandom_range(0, 23)),
                            6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
        send_alarm_beat(OP_ADD, 5'd8, 6'd0, 6'd0, 6'd0, 5'd8, 6'd0, 6'd0);

        // Random part: phases with their own lead, mix of commands and idling
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_lead(6'd0);
                1:       write_lead(6'd59);
                5:       write_lead(6'd1);
                default: write_lead(6'($urandom_range(0, 59)));
            endcase
            // Alternate between filling and emptying so both ends of the table are reached
            add_pct   = (p % 2 == 0) ? 75 : 30;
            tx_steady = (p == 2 || p == 6);
            rx_steady = (p == 2 || p == 7);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                // Hold off the sender mid-phase until the pipeline is empty
                if (p == 3 && k == PHASE_BEATS / 2)
                    drain_results();
                send_random_beat(add_pct);
            end
        end

        drain_results();
        repeat (30) @(negedge clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
